// ----- hw/rtl/clm_pkg.sv -----
// Shared types and constants for the command line keyword matcher.
`default_nettype none

package clm_pkg;

  localparam logic [7:0] KEY_BACKSPACE = 8'd8;
  localparam logic [7:0] KEY_NEWLINE   = 8'd10;
  localparam logic [7:0] CHAR_SPACE    = 8'h20;
  localparam logic [7:0] CHAR_HASH     = 8'h23;

  // Longest keyword; match flags are kept for this many leading positions.
  localparam int KW_SPAN = 6;

  localparam logic [7:0] KW_HELP   [KW_SPAN] = '{8'h68, 8'h65, 8'h6C, 8'h70, 8'h00, 8'h00};
  localparam logic [7:0] KW_HELLO  [KW_SPAN] = '{8'h68, 8'h65, 8'h6C, 8'h6C, 8'h6F, 8'h00};
  localparam logic [7:0] KW_REBOOT [KW_SPAN] = '{8'h72, 8'h65, 8'h62, 8'h6F, 8'h6F, 8'h74};

  localparam logic [1:0] CMD_HELP      = 2'd0;
  localparam logic [1:0] CMD_HELLO     = 2'd1;
  localparam logic [1:0] CMD_REBOOT    = 2'd2;
  localparam logic [1:0] CMD_NOT_FOUND = 2'd3;

  localparam logic ITEM_TX    = 1'b0;
  localparam logic ITEM_EVENT = 1'b1;

  typedef enum logic [1:0] {
    OP_ECHO    = 2'd0,
    OP_BKSP    = 2'd1,
    OP_NEWLINE = 2'd2
  } op_kind_t;

  // One classified word handed from the front end to the sequencer.
  typedef struct packed {
    op_kind_t   kind;
    logic [7:0] data;
    logic [1:0] code;
    logic [3:0] len;
  } cmd_t;

endpackage

`default_nettype wire

// ----- hw/rtl/clm_front.sv -----
// Front end: accepts bytes, tracks the line and classifies each byte.
`default_nettype none

module clm_front
  import clm_pkg::*;
#(
  parameter int LINE_DEPTH = 16
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_rx_byte,
  input  wire logic       q_full,
  output logic            q_push,
  output cmd_t            q_cmd
);

  localparam int CW = $clog2(LINE_DEPTH);
  localparam int LW = (CW > 4) ? CW : 4;
  localparam logic [CW-1:0] LINE_CAP = CW'(LINE_DEPTH - 1);

  logic [CW-1:0]      count_r, count_nxt;
  logic [KW_SPAN-1:0] hit_help_r, hit_hello_r, hit_reboot_r;

  logic          accept;
  logic          ignored;
  logic          is_bksp;
  logic          is_nl;
  logic          store;
  logic [LW-1:0] count_ext;
  logic [3:0]    len;
  logic [1:0]    code;

  assign in_ready  = !q_full;
  assign accept    = in_valid && !q_full;
  assign ignored   = in_rx_byte[7];
  assign is_bksp   = (in_rx_byte == KEY_BACKSPACE);
  assign is_nl     = (in_rx_byte == KEY_NEWLINE);
  assign store     = accept && !ignored && !is_bksp && !is_nl && (count_r < LINE_CAP);
  assign count_ext = LW'(count_r);
  assign len       = (count_ext > LW'(15)) ? 4'd15 : count_ext[3:0];

  always_comb begin
    if (count_r == CW'(4) && (&hit_help_r[3:0])) begin
      code = CMD_HELP;
    end else if (count_r == CW'(5) && (&hit_hello_r[4:0])) begin
      code = CMD_HELLO;
    end else if (count_r == CW'(6) && (&hit_reboot_r[5:0])) begin
      code = CMD_REBOOT;
    end else begin
      code = CMD_NOT_FOUND;
    end
  end

  always_comb begin
    q_push       = accept && !ignored;
    q_cmd.data   = in_rx_byte;
    q_cmd.code   = code;
    q_cmd.len    = len;
    if (is_bksp) begin
      q_cmd.kind = OP_BKSP;
    end else if (is_nl) begin
      q_cmd.kind = OP_NEWLINE;
    end else begin
      q_cmd.kind = OP_ECHO;
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (accept && !ignored) begin
      if (is_nl) begin
        count_nxt = '0;
      end else if (is_bksp) begin
        if (count_r != '0) begin
          count_nxt = count_r - CW'(1);
        end
      end else if (store) begin
        count_nxt = count_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // Only the comparison outcome of each leading character is needed, so
  // the line itself is reduced to one hit bit per keyword and position.
  always_ff @(posedge clk) begin
    for (int p = 0; p < KW_SPAN; p++) begin
      if (store && count_r == CW'(p)) begin
        hit_help_r[p]   <= (in_rx_byte == KW_HELP[p]);
        hit_hello_r[p]  <= (in_rx_byte == KW_HELLO[p]);
        hit_reboot_r[p] <= (in_rx_byte == KW_REBOOT[p]);
      end
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/clm_queue.sv -----
// Two-entry queue of classified words between front end and sequencer.
`default_nettype none

module clm_queue
  import clm_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  cmd_t      push_cmd,
  input  wire logic pop,
  output logic      full,
  output logic      empty,
  output cmd_t      head
);

  cmd_t       slot_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] fill_r;

  assign full  = (fill_r == 2'd2);
  assign empty = (fill_r == 2'd0);
  assign head  = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      fill_r <= fill_r + 2'(push) - 2'(pop);
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/clm_back.sv -----
// Sequencer: expands each classified word into its result words.
`default_nettype none

module clm_back
  import clm_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       q_empty,
  input  cmd_t            q_head,
  output logic            q_pop,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            out_item_kind,
  output logic [7:0]      out_tx_byte,
  output logic [1:0]      out_command_code,
  output logic [3:0]      out_line_length,
  output logic            out_last_of_run
);

  logic [1:0] step_r, step_nxt;
  logic       valid_r;
  logic       kind_r, kind_nxt;
  logic [7:0] tx_r, tx_nxt;
  logic [1:0] code_r, code_nxt;
  logic [3:0] len_r, len_nxt;
  logic       last_r, last_nxt;
  logic       load;

  assign load  = !q_empty && (!valid_r || out_ready);
  assign q_pop = load && last_nxt;

  always_comb begin
    kind_nxt = ITEM_TX;
    tx_nxt   = 8'd0;
    code_nxt = 2'd0;
    len_nxt  = 4'd0;
    last_nxt = 1'b0;
    case (q_head.kind)
      OP_BKSP: begin
        tx_nxt   = (step_r == 2'd1) ? CHAR_SPACE : KEY_BACKSPACE;
        last_nxt = (step_r == 2'd2);
      end
      OP_NEWLINE: begin
        case (step_r)
          2'd0: tx_nxt = KEY_NEWLINE;
          2'd1: begin
            kind_nxt = ITEM_EVENT;
            code_nxt = q_head.code;
            len_nxt  = q_head.len;
          end
          2'd2: tx_nxt = CHAR_HASH;
          default: begin
            tx_nxt   = CHAR_SPACE;
            last_nxt = 1'b1;
          end
        endcase
      end
      default: begin
        tx_nxt   = q_head.data;
        last_nxt = 1'b1;
      end
    endcase
  end

  always_comb begin
    step_nxt = step_r;
    if (load) begin
      step_nxt = last_nxt ? 2'd0 : step_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= 2'd0;
      valid_r <= 1'b0;
    end else begin
      step_r <= step_nxt;
      if (load) begin
        valid_r <= 1'b1;
      end else if (out_ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind_r <= kind_nxt;
      tx_r   <= tx_nxt;
      code_r <= code_nxt;
      len_r  <= len_nxt;
      last_r <= last_nxt;
    end
  end

  assign out_valid        = valid_r;
  assign out_item_kind    = kind_r;
  assign out_tx_byte      = tx_r;
  assign out_command_code = code_r;
  assign out_line_length  = len_r;
  assign out_last_of_run  = last_r;

endmodule

`default_nettype wire

// ----- hw/rtl/command_line_keyword_matcher_core.sv -----
// Top level of the command line keyword matcher: front end, queue, sequencer.
// out_valid for the first result word rises once the accepted byte has passed the queue and
// the output register. The sequencer gives one result word per cycle while out_ready is high;
// a byte yields 1, 3 or 4 result words (echo, backspace, newline); ignored bytes yield none.
// The two-entry queue lets the front end take new bytes while results wait at the output.
// Reset (rst_n low, synchronous) empties the queue and output and zeroes the line length.
`default_nettype none

module command_line_keyword_matcher_core
  import clm_pkg::*;
#(
  parameter int LINE_DEPTH = 16
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_rx_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            out_item_kind,
  output logic [7:0]      out_tx_byte,
  output logic [1:0]      out_command_code,
  output logic [3:0]      out_line_length,
  output logic            out_last_of_run
);

  // Classified words travel from the front end to the sequencer through
  // the queue; the front end decides the command code at newline time,
  // because the line state it needs is cleared by that same byte.
  cmd_t push_cmd;
  cmd_t head;
  logic push;
  logic pop;
  logic full;
  logic empty;

  // The front end keeps the line length and the per-position keyword hits.
  clm_front #(
    .LINE_DEPTH(LINE_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_rx_byte(in_rx_byte),
    .q_full    (full),
    .q_push    (push),
    .q_cmd     (push_cmd)
  );

  clm_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_cmd(push_cmd),
    .pop     (pop),
    .full    (full),
    .empty   (empty),
    .head    (head)
  );

  // The sequencer steps through the result words of the head entry and
  // holds each one in the output register until it is taken.
  clm_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (empty),
    .q_head          (head),
    .q_pop           (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_item_kind   (out_item_kind),
    .out_tx_byte     (out_tx_byte),
    .out_command_code(out_command_code),
    .out_line_length (out_line_length),
    .out_last_of_run (out_last_of_run)
  );

endmodule

`default_nettype wire
